// ----- rtl/kf200_pkg.sv -----
// Shared types, constants and the Keccak-f[200] round function.
// Used by every module of the permutation block; no dependencies.
package kf200_pkg;

  localparam int LANES         = 25;
  localparam int ROUNDS        = 18;
  localparam int CNT_W         = 5;
  localparam int LANE_W        = 8;
  localparam logic [7:0] LFSR_FEEDBACK = 8'h71;
  localparam logic [7:0] LFSR_SEED     = 8'h01;

  typedef logic [LANES-1:0][LANE_W-1:0] state_t;

  // front to queue: a complete state
  typedef struct packed {
    logic   push;
    state_t lanes;
  } q_push_t;

  // queue to back
  typedef struct packed {
    logic   full;
    state_t lanes;
  } q_head_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic [7:0] lfsr;
    logic [7:0] rc;
  } iota_t;

  function automatic logic [7:0] rot8(logic [7:0] v, int n);
    int k;
    k = n % 8;
    if (k == 0) return v;
    return (v << k) | (v >> (8 - k));
  endfunction

  // Seven LFSR steps per round; steps 0..3 may set bits 0, 1, 3 and 7.
  function automatic iota_t iota_step(logic [7:0] lfsr_in);
    iota_t res;
    logic [7:0] l;
    logic fb;
    l = lfsr_in;
    res.rc = '0;
    for (int j = 0; j < 7; j++) begin
      fb = l[7];
      l = (l << 1) ^ (fb ? LFSR_FEEDBACK : 8'h00);
      if (l[1] && (j < 4)) res.rc[(1 << j) - 1] = 1'b1;
    end
    res.lfsr = l;
    return res;
  endfunction

  function automatic state_t kf_round(state_t a, logic [7:0] rc);
    logic [4:0][7:0] c;
    logic [7:0] d;
    state_t t;
    state_t b;
    state_t r;
    int x;
    int y;
    int nx;
    int off;
    int src;
    int dst;
    // theta
    for (int i = 0; i < 5; i++) begin
      c[i] = a[i] ^ a[i+5] ^ a[i+10] ^ a[i+15] ^ a[i+20];
    end
    for (int i = 0; i < 5; i++) begin
      d = c[(i+4)%5] ^ rot8(c[(i+1)%5], 1);
      for (int j = 0; j < 5; j++) begin
        t[i+5*j] = a[i+5*j] ^ d;
      end
    end
    // rho and pi along the 24-lane cycle; lane 0 stays
    b = t;
    x = 1;
    y = 0;
    off = 0;
    src = 1;
    for (int j = 0; j < 24; j++) begin
      off = off + j + 1;
      nx = y;
      y = (2*x + 3*y) % 5;
      x = nx;
      dst = x + 5*y;
      b[dst] = rot8(t[src], off % 8);
      src = dst;
    end
    // chi
    for (int j = 0; j < 5; j++) begin
      for (int i = 0; i < 5; i++) begin
        r[i+5*j] = b[i+5*j] ^ (~b[(i+1)%5+5*j] & b[(i+2)%5+5*j]);
      end
    end
    // iota
    r[0] = r[0] ^ rc;
    return r;
  endfunction

endpackage

// ----- rtl/kf200_front.sv -----
// Front end: shifts incoming bytes into a 25-lane buffer and counts the fill.
// Depends on kf200_pkg.
module kf200_front import kf200_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        state_byte,
  output logic              last_pending,
  output q_push_t           push
);

  logic [CNT_W-1:0] fill_count;
  state_t           lanes;
  state_t           lanes_next;

  // newest byte enters at the top, so the first byte ends in lane 0
  assign lanes_next   = {state_byte, lanes[LANES-1:1]};
  assign last_pending = (fill_count == CNT_W'(LANES - 1));

  assign push.push  = accept && last_pending;
  assign push.lanes = lanes_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      if (last_pending) fill_count <= '0;
      else fill_count <= fill_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) lanes <= lanes_next;
  end

endmodule

// ----- rtl/kf200_queue.sv -----
// One-entry state queue between the byte collector and the round engine.
// Depends on kf200_pkg.
module kf200_queue import kf200_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_push_t push,
  input  logic    pop,
  output q_head_t head
);

  logic   full;
  state_t slot;

  assign head.full  = full;
  assign head.lanes = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= push.push || (full && !pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) slot <= push.lanes;
  end

endmodule

// ----- rtl/kf200_back.sv -----
// Back end: runs one Keccak-f[200] round per cycle, then streams the lanes out.
// Depends on kf200_pkg.
module kf200_back import kf200_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_head_t    head,
  output logic       pop,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last
);

  back_state_t      st;
  back_state_t      st_next;
  logic [CNT_W-1:0] round_cnt;
  logic [CNT_W-1:0] emit_cnt;
  logic [7:0]       lfsr;
  state_t           lanes;
  iota_t            iota;
  logic             round_done;
  logic             emit_done;

  assign iota       = iota_step(lfsr);
  assign round_done = (round_cnt == CNT_W'(ROUNDS - 1));
  assign emit_done  = (emit_cnt == CNT_W'(LANES - 1));

  always_comb begin
    st_next = st;
    case (st)
      BK_IDLE:  if (head.full) st_next = BK_ROUND;
      BK_ROUND: if (round_done) st_next = BK_EMIT;
      BK_EMIT:  if (emit_done) st_next = BK_IDLE;
      default:  st_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    case (st)
      BK_IDLE:  pop = head.full;
      BK_ROUND: pop = 1'b0;
      BK_EMIT:  out_valid = 1'b1;
      default: begin
        pop       = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign out_byte = lanes[0];
  assign out_last = emit_done;

  always_ff @(posedge clk) begin
    if (rst) st <= BK_IDLE;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    case (st)
      BK_IDLE: begin
        lanes     <= head.lanes;
        lfsr      <= LFSR_SEED;
        round_cnt <= '0;
        emit_cnt  <= '0;
      end
      BK_ROUND: begin
        lanes     <= kf_round(lanes, iota.rc);
        lfsr      <= iota.lfsr;
        round_cnt <= round_cnt + CNT_W'(1);
      end
      BK_EMIT: begin
        lanes    <= {LANE_W'(0), lanes[LANES-1:1]};
        emit_cnt <= emit_cnt + CNT_W'(1);
      end
      default: begin
        lanes <= lanes;
      end
    endcase
  end

endmodule

// ----- rtl/keccak_f200_permutation.sv -----
// Keccak-f[200] permutation. Load the 25 state bytes one per request (start
// high while busy is low), lane order x+5*y, lane 0 first. After the 25th
// byte the state passes through a one-entry queue to the round engine, which
// applies 18 rounds at one round per clock and then drives the 25 permuted
// bytes on out_byte, one per cycle, each marked by out_valid for exactly one
// cycle; out_last flags the 25th. The receiver cannot stall the output, so it
// must take every byte in the cycle it appears. A permutation occupies the round
// engine while it takes the state, applies the 18 rounds and outputs the 25
// bytes. The collector accepts one byte per cycle while busy is low and
// fills the next state while the engine works; busy rises only when the
// 25th byte of a new state is waiting and the queue still holds an
// unstarted state. The sustained rate is set by the round engine.
// Depends on kf200_pkg and the kf200_front, kf200_queue, kf200_back modules.
module keccak_f200_permutation import kf200_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] state_byte,
  output logic       busy,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic    accept;
  logic    last_pending;
  logic    pop;
  q_push_t push;
  q_head_t head;

  // only the final byte of a state needs a free queue slot
  assign busy   = last_pending && head.full;
  assign accept = start && !busy;

  kf200_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .state_byte   (state_byte),
    .last_pending (last_pending),
    .push         (push)
  );

  kf200_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head)
  );

  kf200_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ----- test/keccak_f200_permutation_tb.sv -----
// Testbench for the Keccak-f[200] permutation block: byte-serial loading,
// scoreboard prediction of the permuted state, and checks on every output.
// Depends on kf200_pkg and keccak_f200_permutation from the rtl folder.
`timescale 1ns / 100ps

import kf200_pkg::*;

// one expected output byte
typedef struct {
  logic [7:0] data;
  logic       last;
} out_rec_t;

class perm_scoreboard;
  out_rec_t   expected_q[$];
  logic [7:0] fill_lanes[LANES];
  int         fill_pos;
  int         rho_amt[LANES];
  int         pi_dest[LANES];
  logic [7:0] rnd_const[ROUNDS];
  int         errors;
  int         bytes_in;
  int         perms;
  int         bytes_out;

  function new();
    int x;
    int y;
    int nx;
    logic [7:0] lfsr;
    logic [7:0] rc;
    logic fb;
    errors = 0;
    bytes_in = 0;
    perms = 0;
    bytes_out = 0;
    fill_pos = 0;
    foreach (fill_lanes[i]) fill_lanes[i] = '0;
    // rho: triangular offsets along the lane walk from (1,0); lane 0 stays put
    rho_amt[0] = 0;
    x = 1;
    y = 0;
    for (int t = 0; t < 24; t++) begin
      rho_amt[x + 5*y] = ((t + 1) * (t + 2) / 2) % 8;
      nx = y;
      y = (2*x + 3*y) % 5;
      x = nx;
    end
    // pi: (x,y) -> (y, 2x+3y)
    for (int yy = 0; yy < 5; yy++) begin
      for (int xx = 0; xx < 5; xx++) begin
        pi_dest[xx + 5*yy] = yy + 5*((2*xx + 3*yy) % 5);
      end
    end
    // iota constants: LFSR seeded with 1, seven steps per round
    lfsr = 8'h01;
    for (int r = 0; r < ROUNDS; r++) begin
      rc = '0;
      for (int j = 0; j < 7; j++) begin
        fb = lfsr[7];
        lfsr = {lfsr[6:0], 1'b0} ^ (fb ? LFSR_FEEDBACK : 8'h00);
        if (lfsr[1] && (j < 4)) rc[(1 << j) - 1] = 1'b1;
      end
      rnd_const[r] = rc;
    end
  endfunction

  function logic [7:0] rotl8(logic [7:0] v, int n);
    logic [15:0] w;
    w = {v, v} << n;
    return w[15:8];
  endfunction

  // apply all rounds to the collected lanes, in place
  function void permute_lanes();
    logic [7:0] a[LANES];
    logic [7:0] b[LANES];
    logic [7:0] col[5];
    logic [7:0] d;
    foreach (a[i]) a[i] = fill_lanes[i];
    for (int r = 0; r < ROUNDS; r++) begin
      for (int x = 0; x < 5; x++) begin
        col[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
      end
      for (int x = 0; x < 5; x++) begin
        d = col[(x+4)%5] ^ rotl8(col[(x+1)%5], 1);
        for (int y = 0; y < 5; y++) a[x + 5*y] = a[x + 5*y] ^ d;
      end
      for (int i = 0; i < LANES; i++) b[pi_dest[i]] = rotl8(a[i], rho_amt[i]);
      for (int y = 0; y < 5; y++) begin
        for (int x = 0; x < 5; x++) begin
          a[x + 5*y] = b[x + 5*y] ^ (~b[(x+1)%5 + 5*y] & b[(x+2)%5 + 5*y]);
        end
      end
      a[0] = a[0] ^ rnd_const[r];
    end
    foreach (a[i]) fill_lanes[i] = a[i];
  endfunction

  // accepted request: store the byte, predict outputs on the 25th
  function void note_byte(logic [7:0] b);
    out_rec_t rec;
    fill_lanes[fill_pos] = b;
    fill_pos++;
    bytes_in++;
    if (fill_pos == LANES) begin
      fill_pos = 0;
      perms++;
      permute_lanes();
      for (int k = 0; k < LANES; k++) begin
        rec.data = fill_lanes[k];
        rec.last = (k == LANES - 1);
        expected_q.push_back(rec);
      end
    end
  endfunction

  function void check_result(logic [7:0] data, logic last);
    out_rec_t rec;
    bytes_out++;
    if (expected_q.size() == 0) begin
      $error("unexpected output byte %02h (last=%0b)", data, last);
      errors++;
      return;
    end
    rec = expected_q.pop_front();
    if (data !== rec.data) begin
      $error("out_byte mismatch: expected %02h actual %02h", rec.data, data);
      errors++;
    end
    if (last !== rec.last) begin
      $error("out_last mismatch: expected %0b actual %0b", rec.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module keccak_f200_permutation_tb;

  localparam int RAND_STATES = 18;

  logic       clk;
  logic       rst;
  logic       start;
  logic [7:0] state_byte;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  perm_scoreboard sb;

  // directed state: extremes, alternating patterns and single bits
  logic [7:0] directed_bytes[LANES] = '{
    8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h01,
    8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFE, 8'hFD,
    8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'hFF
  };

  keccak_f200_permutation uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .state_byte (state_byte),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Output side cannot stall: every strobed byte is taken in its own cycle.
  // Sampling at the falling edge keeps us clear of the rising-edge updates.
  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1) sb.check_result(out_byte, out_last);
  end

  // Idle length before a request: mostly none, some short, a few long
  // (the longest ones let the engine finish a whole state in the gap).
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Issue one byte request and hold it until the block takes it.
  // start stays high across back-to-back requests.
  task automatic send_byte(input logic [7:0] b, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    state_byte <= b;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_byte(b);
  endtask

  // Random state: mostly random bytes, some uniform or single-bit states.
  task automatic send_random_state();
    int         flavor;
    int         hot_lane;
    int         hot_bit;
    bit         no_gaps;
    logic [7:0] b;
    flavor   = $urandom_range(0, 9);
    hot_lane = $urandom_range(0, LANES - 1);
    hot_bit  = $urandom_range(0, 7);
    no_gaps  = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < LANES; k++) begin
      case (flavor)
        0: b = 8'h00;
        1: b = 8'hFF;
        2: b = (k == hot_lane) ? (8'h01 << hot_bit) : 8'h00;
        default: b = 8'($urandom);
      endcase
      send_byte(b, no_gaps ? 0 : pick_gap());
    end
  endtask

  initial begin
    int waited;
    sb         = new();
    rst        = 1'b1;
    start      = 1'b0;
    state_byte = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed state, sent back to back
    for (int k = 0; k < LANES; k++) send_byte(directed_bytes[k], 0);

    // random states; gap-free ones push the collector into busy
    for (int s = 0; s < RAND_STATES; s++) send_random_state();
    start <= 1'b0;

    // drain: wait for outstanding bytes, then about two permutations more
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected output bytes never arrived", sb.pending());
      sb.errors++;
    end

    $display("Loaded %0d state bytes (%0d permutations), checked %0d output bytes",
             sb.bytes_in, sb.perms, sb.bytes_out);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/kf200_pkg.sv
rtl/kf200_front.sv
rtl/kf200_queue.sv
rtl/kf200_back.sv
rtl/keccak_f200_permutation.sv
test/keccak_f200_permutation_tb.sv
